@@ rtl/core/msl_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package msl_pkg;

    localparam int DEPTH  = 64;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int KEY_W  = 32;
    localparam int LEN_W  = 7;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    // Input tdata: slot, key, keep_upper; output tdata: merged_key, merged_pos.
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 40;

    typedef enum logic [1:0] {
        CMD_LOAD_A = 2'd0,
        CMD_LOAD_B = 2'd1,
        CMD_RUN    = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        REG_LENGTH_A  = 2'd0,
        REG_LENGTH_B  = 2'd1,
        REG_OUT_COUNT = 2'd2,
        REG_UNUSED    = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PRIME,
        ST_MERGE
    } state_t;

endpackage

`default_nettype wire

@@ rtl/core/msl_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module msl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ rtl/core/merge_split_sorted_lists.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Merge-split step of odd-even transposition sort over two 64-entry key stores.
// A load item (command 0 or 1) writes one signed Q15.16 key into list A or B.
// A run item (command 2) merges the two ascending lists and emits
// min(out_count, length_a + length_b, 64) keys, each length clamped to 64:
// the smallest keys at positions 0 upward, or with keep_upper the largest keys
// from the top position downward; on equal keys list B goes first. A run
// primes the list heads in ST_PRIME from the memories' registered read ports,
// then emits one key per cycle in ST_MERGE while m_tready stays high; a run
// with an empty count emits nothing and leaves the block idle. Input items are
// taken again once the last key of a run has entered the output register.

module merge_split_sorted_lists (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // slot [5:0], key [37:6], keep_upper [38], zero [39]
    input  wire logic [msl_pkg::S_DATA_W-1:0]   s_tdata,
    // command [1:0]
    input  wire logic [1:0]                     s_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // merged_key [31:0], merged_pos [37:32], zero [39:38]
    output logic      [msl_pkg::M_DATA_W-1:0]   m_tdata,
    output logic                                m_tlast,
    input  wire logic                           cfg_we,
    input  wire logic [1:0]                     cfg_index,
    input  wire logic [msl_pkg::LEN_W-1:0]      cfg_data
);

    import msl_pkg::*;

    state_t state_reg, state_next;

    logic [LEN_W-1:0] length_a_reg, length_b_reg, out_count_reg;

    logic [ADDR_W-1:0] in_slot;
    logic [KEY_W-1:0]  in_key;
    logic              in_upper;
    cmd_t              in_cmd;
    logic              s_acc;

    logic [CNT_W-1:0] la, lb, count_calc;
    logic [CNT_W:0]   total;

    logic [ADDR_W-1:0] ia_reg, ib_reg, step_reg, step_in;
    logic [CNT_W-1:0]  rem_a_reg, rem_b_reg, rem_reg;
    logic [ADDR_W-1:0] pos_reg;
    logic              upper_reg;
    logic [KEY_W-1:0]  head_a_reg, head_b_reg;

    logic [ADDR_W-1:0] raddr_a, raddr_b;
    logic [KEY_W-1:0]  rdata_a, rdata_b;
    logic              we_a, we_b;

    logic run_start, adv, a_ok, b_ok, take_a, a_beats_b;

    logic             m_valid_reg;
    logic [KEY_W-1:0] m_key_reg;
    logic [ADDR_W-1:0] m_pos_reg;
    logic             m_last_reg;

    assign in_slot  = s_tdata[ADDR_W-1:0];
    assign in_key   = s_tdata[ADDR_W +: KEY_W];
    assign in_upper = s_tdata[ADDR_W + KEY_W];
    assign in_cmd   = cmd_t'(s_tuser);
    assign s_acc    = s_tvalid && s_tready;

    assign we_a = s_acc && (in_cmd == CMD_LOAD_A);
    assign we_b = s_acc && (in_cmd == CMD_LOAD_B);

    // Run length: lengths clamp to the depth, the count to their sum and the depth.
    always_comb
    begin
        la = (length_a_reg > LEN_W'(DEPTH)) ? CNT_W'(DEPTH) : CNT_W'(length_a_reg);
        lb = (length_b_reg > LEN_W'(DEPTH)) ? CNT_W'(DEPTH) : CNT_W'(length_b_reg);
        total = {1'b0, la} + {1'b0, lb};
        if ({1'b0, CNT_W'(out_count_reg)} > total)
        begin
            count_calc = (total > (CNT_W + 1)'(DEPTH)) ? CNT_W'(DEPTH) : total[CNT_W-1:0];
        end
        else if (out_count_reg > LEN_W'(DEPTH))
        begin
            count_calc = CNT_W'(DEPTH);
        end
        else
        begin
            count_calc = CNT_W'(out_count_reg);
        end
    end

    assign run_start = s_acc && (in_cmd == CMD_RUN) && (count_calc != '0);
    assign step_in   = in_upper ? {ADDR_W{1'b1}} : ADDR_W'(1);

    assign a_ok = (rem_a_reg != '0);
    assign b_ok = (rem_b_reg != '0);
    always_comb
    begin
        if (upper_reg)
        begin
            a_beats_b = $signed(head_a_reg) > $signed(head_b_reg);
        end
        else
        begin
            a_beats_b = $signed(head_a_reg) < $signed(head_b_reg);
        end
        take_a = a_ok && (!b_ok || a_beats_b);
    end

    assign adv = (state_reg == ST_MERGE) && (!m_valid_reg || m_tready);

    // During a run each memory reads one entry past its head, so the next head is
    // waiting in the read register when the current one is consumed.
    always_comb
    begin
        raddr_a = ia_reg + step_reg;
        raddr_b = ib_reg + step_reg;
        case (state_reg)
            ST_IDLE:
            begin
                raddr_a = in_upper ? ADDR_W'(la - CNT_W'(1)) : '0;
                raddr_b = in_upper ? ADDR_W'(lb - CNT_W'(1)) : '0;
            end
            ST_PRIME:
            begin
                raddr_a = ia_reg + step_reg;
                raddr_b = ib_reg + step_reg;
            end
            ST_MERGE:
            begin
                if (adv && take_a)
                begin
                    raddr_a = ia_reg + (step_reg << 1);
                end
                if (adv && !take_a)
                begin
                    raddr_b = ib_reg + (step_reg << 1);
                end
            end
            default:
            begin
                raddr_a = ia_reg + step_reg;
                raddr_b = ib_reg + step_reg;
            end
        endcase
    end

    msl_ram #(.WIDTH(KEY_W), .DEPTH(DEPTH)) u_ram_a (
        .clk   (clk),
        .we    (we_a),
        .waddr (in_slot),
        .wdata (in_key),
        .raddr (raddr_a),
        .rdata (rdata_a)
    );

    msl_ram #(.WIDTH(KEY_W), .DEPTH(DEPTH)) u_ram_b (
        .clk   (clk),
        .we    (we_b),
        .waddr (in_slot),
        .wdata (in_key),
        .raddr (raddr_b),
        .rdata (rdata_b)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (run_start)
                begin
                    state_next = ST_PRIME;
                end
            end
            ST_PRIME:
            begin
                state_next = ST_MERGE;
            end
            ST_MERGE:
            begin
                if (adv && (rem_reg == CNT_W'(1)))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        case (state_reg)
            ST_IDLE:  s_tready = 1'b1;
            default:  s_tready = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            length_a_reg  <= '0;
            length_b_reg  <= '0;
            out_count_reg <= '0;
            m_valid_reg   <= 1'b0;
            rem_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (reg_idx_t'(cfg_index))
                    REG_LENGTH_A:  length_a_reg  <= cfg_data;
                    REG_LENGTH_B:  length_b_reg  <= cfg_data;
                    REG_OUT_COUNT: out_count_reg <= cfg_data;
                    default:       ;
                endcase
            end
            if (run_start)
            begin
                rem_reg <= count_calc;
            end
            else if (adv)
            begin
                rem_reg <= rem_reg - CNT_W'(1);
            end
            if (adv)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (run_start)
        begin
            upper_reg <= in_upper;
            step_reg  <= step_in;
            ia_reg    <= raddr_a;
            ib_reg    <= raddr_b;
            rem_a_reg <= la;
            rem_b_reg <= lb;
            pos_reg   <= in_upper ? ADDR_W'(count_calc - CNT_W'(1)) : '0;
        end
        else if (state_reg == ST_PRIME)
        begin
            head_a_reg <= rdata_a;
            head_b_reg <= rdata_b;
        end
        else if (adv)
        begin
            pos_reg <= pos_reg + step_reg;
            if (take_a)
            begin
                head_a_reg <= rdata_a;
                ia_reg     <= ia_reg + step_reg;
                rem_a_reg  <= rem_a_reg - CNT_W'(1);
            end
            else
            begin
                head_b_reg <= rdata_b;
                ib_reg     <= ib_reg + step_reg;
                rem_b_reg  <= rem_b_reg - CNT_W'(1);
            end
        end
        if (adv)
        begin
            m_key_reg  <= take_a ? head_a_reg : head_b_reg;
            m_pos_reg  <= pos_reg;
            m_last_reg <= (rem_reg == CNT_W'(1));
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_DATA_W - KEY_W - ADDR_W){1'b0}}, m_pos_reg, m_key_reg};
    assign m_tlast  = m_last_reg;

endmodule

`default_nettype wire
